// ----- src/pps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int MAX_WAYPOINTS = 1024;
    localparam int AW            = $clog2(MAX_WAYPOINTS);
    localparam int LW            = $clog2(MAX_WAYPOINTS + 1);
    localparam int CORDIC_STEPS  = 16;
    localparam int NUM_W         = 84;
    localparam int CNT_W         = $clog2(NUM_W + 1);
    localparam int MIN_DIST      = 66;

    localparam logic [29:0] K_Q30 = 30'd652032874;

    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_GOAL_TOL  = 2'd1;
    localparam logic [1:0] REG_CRUISE    = 2'd2;

    typedef enum logic [2:0] {
        STATUS_EMPTY    = 3'd0,
        STATUS_NO_AHEAD = 3'd1,
        STATUS_TOO_NEAR = 3'd2,
        STATUS_AT_GOAL  = 3'd3,
        STATUS_DRIVE    = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SINCOS,
        S_READ,
        S_LOAD,
        S_ROT,
        S_RCHK,
        S_VEC,
        S_KMUL,
        S_DCHK,
        S_FOUND,
        S_SPEED,
        S_DIV1,
        S_DIV2,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        M_GOAL,
        M_SCAN,
        M_FALL
    } mode_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            5'd30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- src/pure_pursuit_steering.sv -----
`timescale 1ns / 1ps
`default_nettype none
// pure pursuit steering engine
// s_ channel: one transfer per item. tuser[0] selects the kind: 0 appends the
// waypoint in tdata to the path store (tuser[1] starts a fresh path first),
// 1 is a control tick carrying the robot pose and heading.
// m_ channel: one transfer per tick with status in tuser and speed, turn rate
// and target slot in tdata; appends produce nothing.
// an append is written straight to the store; a full store silently drops it.
// a tick runs a sequencer over the path memory: the cordic for sin/cos, then
// the goal distance, then per scanned waypoint the rotation into the robot
// frame plus the vectoring and distance check when the point lies ahead, the
// final-point fallback, and at last the speed product and the two bit-serial
// divides of the turn rate.
// worst case the run time grows with the number N of stored points, set by
// the single read port of the waypoint memory; the next item can be taken in
// the cycle after the result is loaded.
// one item is in work at a time; s_tready is high only while idle.
// when the receiver stalls the finished result waits in the output register;
// appends and the next tick are still taken, and the next result holds in the
// finish step until the waiting one is taken.
// reset (synchronous, active low) empties the path and restores the
// register defaults; the waypoint memory itself is not cleared.
// apb registers: 0x0 lookahead, 0x4 goal tolerance, 0x8 cruise speed.

module pure_pursuit_steering (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // apb configuration
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready,
    // input items
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // waypoint_x[31:0], waypoint_y[63:32], pose_x[95:64], pose_y[127:96],
    // heading[143:128]
    input  wire logic [143:0] s_tdata,
    // action[0], new_path[1]
    input  wire logic [1:0]   s_tuser,
    // results
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // forward_speed[30:0], turn_rate[62:31], target_slot[72:63], zero pad
    output logic      [79:0]  m_tdata,
    // status[2:0]
    output logic      [2:0]   m_tuser
);

    localparam int AW    = pps_pkg::AW;
    localparam int LW    = pps_pkg::LW;
    localparam int CNT_W = pps_pkg::CNT_W;
    localparam int NUM_W = pps_pkg::NUM_W;

    // configuration registers
    logic [30:0] lookahead_reg, goal_tol_reg, cruise_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lookahead_reg <= 31'd65536;
            goal_tol_reg  <= 31'd19661;
            cruise_reg    <= 31'd6554;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                pps_pkg::REG_LOOKAHEAD: lookahead_reg <= pwdata[30:0];
                pps_pkg::REG_GOAL_TOL:  goal_tol_reg  <= pwdata[30:0];
                pps_pkg::REG_CRUISE:    cruise_reg    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            pps_pkg::REG_LOOKAHEAD: prdata = {1'b0, lookahead_reg};
            pps_pkg::REG_GOAL_TOL:  prdata = {1'b0, goal_tol_reg};
            pps_pkg::REG_CRUISE:    prdata = {1'b0, cruise_reg};
            default:                prdata = 32'd0;
        endcase
    end

    // control state
    pps_pkg::state_t  state_reg, state_next;
    pps_pkg::mode_t   mode_reg;
    pps_pkg::status_t res_status_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [LW-1:0]    len_reg;
    logic [AW-1:0]    idx_reg, rd_addr_reg, tgt_reg, last_idx;

    // waypoint memory, one write and one read port
    logic [31:0] mem_x [pps_pkg::MAX_WAYPOINTS];
    logic [31:0] mem_y [pps_pkg::MAX_WAYPOINTS];
    logic [31:0] rd_x_reg, rd_y_reg;

    logic          s_xfer, app_xfer, tick_xfer, wr_en;
    logic [LW-1:0] wr_idx;

    assign s_xfer    = s_tvalid && s_tready;
    assign app_xfer  = s_xfer && !s_tuser[0];
    assign tick_xfer = s_xfer && s_tuser[0];
    assign wr_idx    = s_tuser[1] ? '0 : len_reg;
    assign wr_en     = app_xfer && (wr_idx < LW'(pps_pkg::MAX_WAYPOINTS));
    assign last_idx  = AW'(len_reg - LW'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_idx[AW-1:0]] <= s_tdata[31:0];
            mem_y[wr_idx[AW-1:0]] <= s_tdata[63:32];
        end
        rd_x_reg <= mem_x[rd_addr_reg];
        rd_y_reg <= mem_y[rd_addr_reg];
    end

    // pose and working registers
    logic [31:0] px_reg, py_reg;
    logic [15:0] hd_reg;

    logic signed [32:0] cx_reg, cy_reg, cz_reg;   // sin/cos cordic
    logic signed [32:0] cos_reg, sin_reg;         // Q2.30
    logic signed [32:0] dx_reg, dy_reg;
    logic signed [35:0] vx_reg, vy_reg;           // vectoring cordic
    logic signed [65:0] prod_reg;
    logic signed [66:0] acc_xr_reg, acc_yr_reg;
    logic        [47:0] kprod_reg;
    logic        [65:0] kacc_reg;
    logic        [34:0] goal_d_reg, dist_reg;
    logic signed [36:0] lat_reg;
    logic        [48:0] sprod_reg;
    logic        [66:0] sacc_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic        [34:0] rem_reg;
    logic        [31:0] rate_reg;

    // output register
    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic [30:0] out_speed_reg;
    logic [31:0] out_rate_reg;
    logic [AW-1:0] out_slot_reg;

    // combinational datapath pieces
    logic signed [32:0] dx_new, dy_new;
    logic signed [32:0] c_xs, c_ys, atan_s;
    logic signed [35:0] v_xs, v_ys, vabs_new, vabs_reg;
    logic signed [32:0] rot_a, rot_b;
    logic               xr_pos, out_free;
    logic        [34:0] d_now;
    logic        [35:0] alat, r2;
    logic               ge;
    logic [NUM_W-1:0]   quo_step, lim, q_sat;
    logic        [31:0] mag;
    logic               last_iter, cordic_done;

    assign dx_new   = $signed({rd_x_reg[31], rd_x_reg}) - $signed({px_reg[31], px_reg});
    assign dy_new   = $signed({rd_y_reg[31], rd_y_reg}) - $signed({py_reg[31], py_reg});
    assign vabs_new = dx_new[32] ? -36'(dx_new) : 36'(dx_new);
    assign vabs_reg = dx_reg[32] ? -36'(dx_reg) : 36'(dx_reg);

    assign c_xs   = cx_reg >>> cnt_reg;
    assign c_ys   = cy_reg >>> cnt_reg;
    assign atan_s = $signed({1'b0, pps_pkg::atan_lut(cnt_reg[4:0])});
    assign v_xs   = vx_reg >>> cnt_reg;
    assign v_ys   = vy_reg >>> cnt_reg;
    assign cordic_done = (cnt_reg == CNT_W'(pps_pkg::CORDIC_STEPS));

    always_comb begin
        case (cnt_reg[1:0])
            2'd0:    begin rot_a = cos_reg; rot_b = dx_reg; end
            2'd1:    begin rot_a = sin_reg; rot_b = dy_reg; end
            2'd2:    begin rot_a = cos_reg; rot_b = dy_reg; end
            default: begin rot_a = sin_reg; rot_b = dx_reg; end
        endcase
    end

    // robot-frame x is positive when the floored shift is positive
    assign xr_pos = !acc_xr_reg[66] && (|acc_xr_reg[66:30]);
    assign d_now  = kacc_reg[64:30];
    assign alat   = lat_reg[36] ? 36'(-lat_reg) : 36'(lat_reg);

    // restoring divide step
    assign r2       = {rem_reg, quo_reg[NUM_W-1]};
    assign ge       = (r2 >= {1'b0, dist_reg});
    assign quo_step = {quo_reg[NUM_W-2:0], ge};
    assign last_iter = (cnt_reg == CNT_W'(NUM_W - 1));

    assign lim   = lat_reg[36] ? NUM_W'(64'h8000_0000) : NUM_W'(64'h7FFF_FFFF);
    assign q_sat = (quo_step > lim) ? lim : quo_step;
    assign mag   = q_sat[31:0];

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pps_pkg::S_IDLE:
                if (tick_xfer) state_next = (len_reg == '0) ? pps_pkg::S_FIN
                                                            : pps_pkg::S_SINCOS;
            pps_pkg::S_SINCOS: if (cordic_done) state_next = pps_pkg::S_READ;
            pps_pkg::S_READ:   state_next = pps_pkg::S_LOAD;
            pps_pkg::S_LOAD:
                state_next = (mode_reg == pps_pkg::M_GOAL) ? pps_pkg::S_VEC : pps_pkg::S_ROT;
            pps_pkg::S_ROT:    if (cnt_reg == CNT_W'(4)) state_next = pps_pkg::S_RCHK;
            pps_pkg::S_RCHK: begin
                if (mode_reg == pps_pkg::M_FALL)
                    state_next = xr_pos ? pps_pkg::S_FOUND : pps_pkg::S_FIN;
                else
                    state_next = xr_pos ? pps_pkg::S_VEC : pps_pkg::S_READ;
            end
            pps_pkg::S_VEC:    if (cordic_done) state_next = pps_pkg::S_KMUL;
            pps_pkg::S_KMUL:   if (cnt_reg == CNT_W'(2)) state_next = pps_pkg::S_DCHK;
            pps_pkg::S_DCHK: begin
                if (mode_reg == pps_pkg::M_GOAL)
                    state_next = (d_now < {4'd0, goal_tol_reg}) ? pps_pkg::S_FIN
                                                                : pps_pkg::S_READ;
                else
                    state_next = (d_now >= {4'd0, lookahead_reg}) ? pps_pkg::S_FOUND
                                                                  : pps_pkg::S_READ;
            end
            pps_pkg::S_FOUND:
                state_next = (dist_reg < 35'(pps_pkg::MIN_DIST)) ? pps_pkg::S_FIN
                                                                 : pps_pkg::S_SPEED;
            pps_pkg::S_SPEED:  if (cnt_reg == CNT_W'(2)) state_next = pps_pkg::S_DIV1;
            pps_pkg::S_DIV1:   if (last_iter) state_next = pps_pkg::S_DIV2;
            pps_pkg::S_DIV2:   if (last_iter) state_next = pps_pkg::S_FIN;
            pps_pkg::S_FIN:    if (out_free) state_next = pps_pkg::S_IDLE;
            default:           state_next = pps_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == pps_pkg::S_IDLE);
        m_tvalid = out_valid_reg;
        m_tuser  = out_status_reg;
        m_tdata  = {7'd0, out_slot_reg, out_rate_reg, out_speed_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pps_pkg::S_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (wr_en) len_reg <= wr_idx + LW'(1);
            if (state_reg == pps_pkg::S_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            pps_pkg::S_IDLE: begin
                px_reg         <= s_tdata[95:64];
                py_reg         <= s_tdata[127:96];
                hd_reg         <= s_tdata[143:128];
                cx_reg         <= 33'(pps_pkg::K_Q30);
                cy_reg         <= '0;
                cz_reg         <= $signed({3'd0, s_tdata[141:128], 16'd0});
                cnt_reg        <= '0;
                rd_addr_reg    <= last_idx;
                mode_reg       <= pps_pkg::M_GOAL;
                res_status_reg <= pps_pkg::STATUS_EMPTY;
            end
            pps_pkg::S_SINCOS: begin
                if (!cordic_done) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (!cz_reg[32]) begin
                        cx_reg <= cx_reg - c_ys;
                        cy_reg <= cy_reg + c_xs;
                        cz_reg <= cz_reg - atan_s;
                    end else begin
                        cx_reg <= cx_reg + c_ys;
                        cy_reg <= cy_reg - c_xs;
                        cz_reg <= cz_reg + atan_s;
                    end
                end else begin
                    case (hd_reg[15:14])
                        2'd0:    begin cos_reg <= cx_reg;  sin_reg <= cy_reg;  end
                        2'd1:    begin cos_reg <= -cy_reg; sin_reg <= cx_reg;  end
                        2'd2:    begin cos_reg <= -cx_reg; sin_reg <= -cy_reg; end
                        default: begin cos_reg <= cy_reg;  sin_reg <= -cx_reg; end
                    endcase
                end
            end
            pps_pkg::S_LOAD: begin
                dx_reg  <= dx_new;
                dy_reg  <= dy_new;
                vx_reg  <= vabs_new;
                vy_reg  <= 36'(dy_new);
                cnt_reg <= '0;
            end
            pps_pkg::S_ROT: begin
                cnt_reg  <= cnt_reg + CNT_W'(1);
                prod_reg <= rot_a * rot_b;
                case (cnt_reg[2:0])
                    3'd1:    acc_xr_reg <= 67'(prod_reg);
                    3'd2:    acc_xr_reg <= acc_xr_reg + 67'(prod_reg);
                    3'd3:    acc_yr_reg <= 67'(prod_reg);
                    3'd4:    acc_yr_reg <= acc_yr_reg - 67'(prod_reg);
                    default: ;
                endcase
            end
            pps_pkg::S_RCHK: begin
                cnt_reg <= '0;
                vx_reg  <= vabs_reg;
                vy_reg  <= 36'(dy_reg);
                if (mode_reg == pps_pkg::M_FALL) begin
                    dist_reg <= goal_d_reg;
                    tgt_reg  <= last_idx;
                    lat_reg  <= acc_yr_reg[66:30];
                    res_status_reg <= pps_pkg::STATUS_NO_AHEAD;
                end else if (!xr_pos) begin
                    // not ahead: move on, or fall back to the final point
                    if (idx_reg == last_idx) begin
                        mode_reg    <= pps_pkg::M_FALL;
                        rd_addr_reg <= last_idx;
                    end else begin
                        idx_reg     <= idx_reg + AW'(1);
                        rd_addr_reg <= idx_reg + AW'(1);
                    end
                end
            end
            pps_pkg::S_VEC: begin
                if (!cordic_done) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (!vy_reg[35]) begin
                        vx_reg <= vx_reg + v_ys;
                        vy_reg <= vy_reg - v_xs;
                    end else begin
                        vx_reg <= vx_reg - v_ys;
                        vy_reg <= vy_reg + v_xs;
                    end
                end else begin
                    cnt_reg <= '0;
                    if (vx_reg[35]) vx_reg <= '0;
                end
            end
            pps_pkg::S_KMUL: begin
                // magnitude times K in two partial products
                cnt_reg <= cnt_reg + CNT_W'(1);
                case (cnt_reg[1:0])
                    2'd0:    kprod_reg <= 48'(vx_reg[17:0]) * 48'(pps_pkg::K_Q30);
                    2'd1: begin
                        kacc_reg  <= 66'(kprod_reg);
                        kprod_reg <= 48'(vx_reg[34:18]) * 48'(pps_pkg::K_Q30);
                    end
                    default: kacc_reg <= kacc_reg + {kprod_reg, 18'd0};
                endcase
            end
            pps_pkg::S_DCHK: begin
                if (mode_reg == pps_pkg::M_GOAL) begin
                    goal_d_reg     <= d_now;
                    mode_reg       <= pps_pkg::M_SCAN;
                    idx_reg        <= '0;
                    rd_addr_reg    <= '0;
                    res_status_reg <= pps_pkg::STATUS_AT_GOAL;
                end else if (d_now >= {4'd0, lookahead_reg}) begin
                    dist_reg <= d_now;
                    tgt_reg  <= idx_reg;
                    lat_reg  <= acc_yr_reg[66:30];
                end else if (idx_reg == last_idx) begin
                    mode_reg    <= pps_pkg::M_FALL;
                    rd_addr_reg <= last_idx;
                end else begin
                    idx_reg     <= idx_reg + AW'(1);
                    rd_addr_reg <= idx_reg + AW'(1);
                end
            end
            pps_pkg::S_FOUND: begin
                cnt_reg        <= '0;
                res_status_reg <= pps_pkg::STATUS_TOO_NEAR;
            end
            pps_pkg::S_SPEED: begin
                rem_reg <= '0;
                case (cnt_reg[1:0])
                    2'd0: begin
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        sprod_reg <= 49'(cruise_reg) * 49'(alat[17:0]);
                    end
                    2'd1: begin
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        sacc_reg  <= 67'(sprod_reg);
                        sprod_reg <= 49'(cruise_reg) * 49'(alat[35:18]);
                    end
                    default: begin
                        cnt_reg <= '0;
                        quo_reg <= {(sacc_reg + {sprod_reg, 18'd0}), 17'd0};
                    end
                endcase
            end
            pps_pkg::S_DIV1, pps_pkg::S_DIV2: begin
                if (last_iter) begin
                    cnt_reg <= '0;
                    rem_reg <= '0;
                end else begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    rem_reg <= ge ? 35'(r2 - {1'b0, dist_reg}) : r2[34:0];
                end
                quo_reg <= quo_step;
                if (state_reg == pps_pkg::S_DIV2 && last_iter) begin
                    rate_reg       <= lat_reg[36] ? -mag : mag;
                    res_status_reg <= pps_pkg::STATUS_DRIVE;
                end
            end
            pps_pkg::S_FIN: begin
                if (out_free) begin
                    out_status_reg <= res_status_reg;
                    if (res_status_reg == pps_pkg::STATUS_DRIVE) begin
                        out_speed_reg <= cruise_reg;
                        out_rate_reg  <= rate_reg;
                        out_slot_reg  <= tgt_reg;
                    end else begin
                        out_speed_reg <= '0;
                        out_rate_reg  <= '0;
                        out_slot_reg  <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    // path never grows past the store
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(pps_pkg::MAX_WAYPOINTS))
        else $error("path length beyond store");

    // non-drive results carry zero command fields
    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != pps_pkg::STATUS_DRIVE) |->
            (m_tdata[30:0] == '0 && m_tdata[62:31] == '0 && m_tdata[72:63] == '0))
        else $error("command fields set without drive status");

    // divider never sees a too-small divisor
    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pps_pkg::S_DIV1) |-> (dist_reg >= 35'(pps_pkg::MIN_DIST)))
        else $error("divide with distance under minimum");

    // a result is only produced from the finish step
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == pps_pkg::S_FIN))
        else $error("result raised outside finish step");

endmodule

`default_nettype wire

// ----- test/tb_pure_pursuit_steering.sv -----
`timescale 1ns / 1ps

// expected steering commands, worked out from the path and pose of each tick
class steer_scoreboard;
    bit [30:0] lookahead;
    bit [30:0] goal_tol;
    bit [30:0] cruise;
    int        path_x[1024];
    int        path_y[1024];
    int unsigned path_len;
    longint    cos_v;
    longint    sin_v;
    bit [75:0] pending_cmds[$];   // {status, speed, rate, slot}
    int        errors;

    localparam longint KQ = 652032874;
    localparam longint ATAN[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861};

    function new();
        lookahead = 31'd65536;
        goal_tol  = 31'd19661;
        cruise    = 31'd6554;
        path_len  = 0;
        errors    = 0;
    endfunction

    function void write_reg(int idx, bit [31:0] value);
        if (idx == 0) lookahead = value[30:0];
        else if (idx == 1) goal_tol = value[30:0];
        else if (idx == 2) cruise = value[30:0];
    endfunction

    // heading reduced to a quadrant, residue rotated by cordic
    function void heading_sincos(bit [15:0] hd);
        longint x, y, z, xs, ys;
        x = KQ;
        y = 0;
        z = longint'({hd[13:0], 16'd0});
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - ATAN[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ATAN[i];
            end
        end
        case (hd[15:14])
            2'd0: begin cos_v = x;  sin_v = y;  end
            2'd1: begin cos_v = -y; sin_v = x;  end
            2'd2: begin cos_v = -x; sin_v = -y; end
            default: begin cos_v = y; sin_v = -x; end
        endcase
    endfunction

    function longint hypot_len(longint dx, longint dy);
        longint x, y, xs, ys;
        logic [95:0] p;
        x = (dx < 0) ? -dx : dx;
        y = dy;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs;
            end else begin
                x = x - ys; y = y + xs;
            end
        end
        if (x < 0) x = 0;
        p = {32'd0, x} * 96'd652032874;
        return longint'(p >> 30);
    endfunction

    function void robot_frame(longint dx, longint dy, output longint xr, output longint yr);
        logic signed [95:0] c, s, a, b;
        c = cos_v;
        s = sin_v;
        a = c * 96'(dx) + s * 96'(dy);
        b = c * 96'(dy) - s * 96'(dx);
        xr = longint'(a >>> 30);
        yr = longint'(b >>> 30);
    endfunction

    function void note_item(bit action, bit new_path, bit [31:0] wx, bit [31:0] wy,
                            bit [31:0] px, bit [31:0] py, bit [15:0] hd);
        bit [2:0]  status;
        bit [30:0] speed;
        bit [31:0] rate;
        bit [9:0]  slot;
        longint    pxl, pyl, gdx, gdy, dx, dy, xr, yr, d, tgt_dist, lat;
        bit        found, neg;
        int unsigned tgt;
        logic [127:0] n, q;
        logic [63:0] alat, lim, mag;
        if (!action) begin
            if (new_path) path_len = 0;
            if (path_len < 1024) begin
                path_x[path_len] = wx;
                path_y[path_len] = wy;
                path_len++;
            end
            return;
        end
        status = pps_pkg::STATUS_EMPTY;
        speed  = '0;
        rate   = '0;
        slot   = '0;
        if (path_len != 0) begin
            pxl = longint'(signed'(px));
            pyl = longint'(signed'(py));
            gdx = longint'(path_x[path_len-1]) - pxl;
            gdy = longint'(path_y[path_len-1]) - pyl;
            heading_sincos(hd);
            if (hypot_len(gdx, gdy) < longint'(goal_tol)) begin
                status = pps_pkg::STATUS_AT_GOAL;
            end else begin
                found    = 0;
                tgt      = 0;
                tgt_dist = 0;
                lat      = 0;
                for (int unsigned i = 0; i < path_len && !found; i++) begin
                    dx = longint'(path_x[i]) - pxl;
                    dy = longint'(path_y[i]) - pyl;
                    robot_frame(dx, dy, xr, yr);
                    if (xr > 0) begin
                        d = hypot_len(dx, dy);
                        if (d >= longint'(lookahead)) begin
                            found = 1; tgt = i; tgt_dist = d; lat = yr;
                        end
                    end
                end
                // fall back to the final waypoint when it lies ahead
                if (!found) begin
                    robot_frame(gdx, gdy, xr, yr);
                    if (xr > 0) begin
                        found = 1; tgt = path_len - 1; tgt_dist = hypot_len(gdx, gdy);
                        lat = yr;
                    end
                end
                if (!found) begin
                    status = pps_pkg::STATUS_NO_AHEAD;
                end else if (tgt_dist < 66) begin
                    status = pps_pkg::STATUS_TOO_NEAR;
                end else begin
                    neg  = lat < 0;
                    alat = neg ? -lat : lat;
                    n    = (128'(cruise) * 128'(alat)) << 17;
                    q    = (n / 128'(tgt_dist)) / 128'(tgt_dist);
                    lim  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
                    mag  = (q > 128'(lim)) ? lim : q[63:0];
                    rate = neg ? (32'd0 - mag[31:0]) : mag[31:0];
                    status = pps_pkg::STATUS_DRIVE;
                    speed  = cruise;
                    slot   = tgt[9:0];
                end
            end
        end
        pending_cmds.push_back({status, speed, rate, slot});
    endfunction

    function void check_result(bit [2:0] tuser, bit [79:0] tdata);
        bit [75:0] e;
        if (pending_cmds.size() == 0) begin
            $display("%0t: unexpected result status %0d data %h", $time, tuser, tdata);
            errors++;
            return;
        end
        e = pending_cmds.pop_front();
        if (tuser !== e[75:73]) begin
            $display("%0t: status expected %0d actual %0d", $time, e[75:73], tuser);
            errors++;
        end
        if (tdata[30:0] !== e[72:42]) begin
            $display("%0t: forward_speed expected %h actual %h", $time, e[72:42], tdata[30:0]);
            errors++;
        end
        if (tdata[62:31] !== e[41:10]) begin
            $display("%0t: turn_rate expected %h actual %h", $time, e[41:10], tdata[62:31]);
            errors++;
        end
        if (tdata[72:63] !== e[9:0]) begin
            $display("%0t: target_slot expected %0d actual %0d", $time, e[9:0], tdata[72:63]);
            errors++;
        end
        if (tdata[79:73] !== 7'd0) begin
            $display("%0t: pad expected 0 actual %h", $time, tdata[79:73]);
            errors++;
        end
    endfunction
endclass

module tb_pure_pursuit_steering;

    localparam int MAX_CYCLES = 4_000_000;
    localparam int M = 65536;   // one metre in Q15.16

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // waypoint_x, waypoint_y, pose_x, pose_y, heading from the lowest bit up
    logic [143:0] s_tdata  = '0;
    // action, new_path from the lowest bit up
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // forward_speed, turn_rate, target_slot, zero pad from the lowest bit up
    logic [79:0]  m_tdata;
    // status
    logic [2:0]   m_tuser;

    steer_scoreboard steer_sb = new();
    int           cycle_count = 0;
    int           send_gap_max = 14;   // per-phase ceiling of sender idle cycles
    int           recv_gap_max = 14;   // per-phase ceiling of receiver stall cycles
    int           items_sent = 0;

    pure_pursuit_steering i_dut (.*);

    always #4 aclk = ~aclk;

    // watchdog over the whole run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stall, then hold tready until one transfer
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            stall = $urandom_range(recv_gap_max, 0);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            steer_sb.check_result(m_tuser, m_tdata);
        end
    end

    // one input transfer, tvalid stays high across back-to-back items
    task automatic send_item(bit action, bit new_path, bit [31:0] wx, bit [31:0] wy,
                             bit [31:0] px, bit [31:0] py, bit [15:0] hd);
        int gap;
        gap = $urandom_range(send_gap_max, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {new_path, action};
        s_tdata  <= {hd, py, px, wy, wx};
        do @(posedge aclk); while (!s_tready);
        steer_sb.note_item(action, new_path, wx, wy, px, py, hd);
        items_sent++;
    endtask

    task automatic append_wp(bit new_path, int wx, int wy);
        send_item(1'b0, new_path, wx, wy, $urandom, $urandom, 16'($urandom));
    endtask

    task automatic tick(int px, int py, bit [15:0] hd);
        send_item(1'b1, 1'($urandom_range(1, 0)), $urandom, $urandom, px, py, hd);
    endtask

    // drain all expected results, then idle on so trailing appends settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (steer_sb.pending_cmds.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // setup then access cycle, register written at the access edge
    task automatic apb_write(logic [1:0] idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        steer_sb.write_reg(int'(idx), value);
    endtask

    task automatic set_regs(bit [31:0] look, bit [31:0] tol, bit [31:0] speed);
        wait_idle();
        apb_write(pps_pkg::REG_LOOKAHEAD, look);
        apb_write(pps_pkg::REG_GOAL_TOL, tol);
        apb_write(pps_pkg::REG_CRUISE, speed);
    endtask

    function automatic int near(int c, int span);
        return c + $signed($urandom_range(2 * span, 0)) - span;
    endfunction

    initial begin
        int cx, cy, len, nt;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: empty path, with new_path set on the tick
        send_item(1'b1, 1'b1, '0, '0, 32'd0, 32'd0, 16'd0);
        // single point ahead, then headings across the four quadrants
        append_wp(1'b1, 2 * M, M);
        tick(0, 0, 16'h0000);
        tick(0, 0, 16'h4000);
        tick(0, 0, 16'h8000);
        tick(0, 0, 16'hC000);
        tick(-M, 0, 16'hFFFF);
        // robot standing on the final waypoint stops at the goal
        tick(2 * M, M, 16'h1234);
        // coordinate extremes
        append_wp(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        append_wp(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
        tick(32'h8000_0000, 32'h8000_0000, 16'h0000);
        tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000);
        tick(32'h8000_0000, 32'h7FFF_FFFF, 16'hE000);

        // extreme registers: no goal stop, lookahead never met, top speed
        set_regs(32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        append_wp(1'b1, 50, 0);        // target too close
        tick(0, 0, 16'h0000);
        append_wp(1'b1, 200, 200);     // turn rate saturates positive
        tick(0, 0, 16'h0000);
        append_wp(1'b1, 200, -200);    // and negative
        tick(0, 0, 16'h0000);
        append_wp(1'b1, -M, 0);        // nothing ahead
        tick(0, 0, 16'h0000);
        // unknown register index is ignored
        wait_idle();
        apb_write(2'd3, 32'hFFFF_FFFF);
        set_regs(32'd0, 32'h7FFF_FFFF, 32'd0);
        tick(0, 0, 16'h0000);          // everything within goal tolerance

        // full store: appends past capacity are dropped
        set_regs(32'd3 * M, 32'd1000, 32'd2 * M);
        send_gap_max = 0;
        recv_gap_max = 0;
        append_wp(1'b1, 0, 0);
        for (int i = 1; i < 1030; i++) append_wp(1'b0, (i % 64) * M / 4, (i % 7) * 100);
        tick(-M, 0, 16'h0000);
        tick(20 * M, M, 16'h8000);
        send_gap_max = 14;
        recv_gap_max = 14;

        // random: well-formed paths with ticks near them, mixed with noise
        items_sent = 0;
        while (items_sent < 290) begin
            if (items_sent % 70 < 3) begin
                case ($urandom_range(3, 0))
                    0: set_regs($urandom_range(8 * M, 0), $urandom_range(M, 0),
                                $urandom_range(4 * M, 0));
                    1: set_regs($urandom, $urandom, $urandom);
                    2: set_regs(32'd0, 32'd0, 32'h7FFF_FFFF);
                    default: set_regs(32'd65536, 32'd19661, 32'd6554);
                endcase
                send_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 14;
                recv_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 14;
            end
            if ($urandom_range(3, 0) != 0) begin
                cx  = near(0, 40 * M);
                cy  = near(0, 40 * M);
                len = $urandom_range(12, 1);
                for (int i = 0; i < len; i++)
                    append_wp(i == 0, near(cx, 5 * M), near(cy, 5 * M));
                nt = $urandom_range(4, 1);
                for (int i = 0; i < nt; i++)
                    tick(near(cx, 5 * M), near(cy, 5 * M), 16'($urandom));
            end else if ($urandom_range(1, 0)) begin
                tick($urandom, $urandom, 16'($urandom));
            end else begin
                append_wp(1'($urandom_range(1, 0)), $urandom, $urandom);
            end
        end

        wait_idle();
        repeat (2000) @(posedge aclk);
        if (steer_sb.errors == 0 && steer_sb.pending_cmds.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
src/pps_pkg.sv
src/pure_pursuit_steering.sv
test/tb_pure_pursuit_steering.sv
